>>> hdl/rti_pkg.sv
// Shared types, constants and arithmetic helpers for the ray/triangle intersection core.
package rti_pkg;

    // Field widths
    localparam int COORD_W    = 16;               // signed coordinate width
    localparam int TAG_W      = 8;
    localparam int OUTC_W     = 3;
    localparam int DET_THR_W  = 40;               // determinant threshold register
    localparam int CFG_DATA_W = 40;               // widest register
    localparam int CFG_IDX_W  = 3;
    localparam int FRACTION_BITS_DEF = 8;

    // Internal widths, all exact
    localparam int DIFF_W = COORD_W + 1;          // vertex differences
    localparam int PROD_W = 2 * COORD_W + 3;      // cross product terms
    localparam int DOT_W  = 3 * COORD_W + 6;      // det, u, v, t numerators

    // Vector component positions
    localparam int AX_X = 0;
    localparam int AX_Y = 1;
    localparam int AX_Z = 2;

    // Outcome codes
    localparam logic [OUTC_W-1:0] OUTC_HIT   = 3'd0;
    localparam logic [OUTC_W-1:0] OUTC_DET   = 3'd1;
    localparam logic [OUTC_W-1:0] OUTC_U_OUT = 3'd2;
    localparam logic [OUTC_W-1:0] OUTC_V_OUT = 3'd3;
    localparam logic [OUTC_W-1:0] OUTC_T_OUT = 3'd4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RAY_LEN  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DET  = 3'd7;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [DOT_W-1:0]   dot_t;

    typedef struct packed {
        logic [TAG_W-1:0] tri_tag;
        coord_t           vertex_a_x;
        coord_t           vertex_a_y;
        coord_t           vertex_a_z;
        coord_t           vertex_b_x;
        coord_t           vertex_b_y;
        coord_t           vertex_b_z;
        coord_t           vertex_c_x;
        coord_t           vertex_c_y;
        coord_t           vertex_c_z;
    } tri_in_t;

    typedef struct packed {
        logic              hit;
        logic [OUTC_W-1:0] outcome;
        logic [TAG_W-1:0]  result_tag;
    } res_out_t;

    typedef struct packed {
        coord_t                 origin_x;
        coord_t                 origin_y;
        coord_t                 origin_z;
        coord_t                 dir_x;
        coord_t                 dir_y;
        coord_t                 dir_z;
        logic [COORD_W-1:0]     ray_length;
        logic [DET_THR_W-1:0]   min_determinant;
    } ray_cfg_t;

    // Edges, origin offset and both cross products of one triangle
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        diff_t [2:0]      e1;
        diff_t [2:0]      e2;
        diff_t [2:0]      s;
        prod_t [2:0]      p;
        prod_t [2:0]      q;
    } geom_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        dot_t             det;
        dot_t             un;
        dot_t             vn;
        dot_t             tn;
    } dots_t;

    function automatic diff_t sub_cc(coord_t a, coord_t b);
        return diff_t'(a) - diff_t'(b);
    endfunction

    function automatic prod_t mul_cd(coord_t a, diff_t b);
        return prod_t'(a) * prod_t'(b);
    endfunction

    function automatic prod_t mul_dd(diff_t a, diff_t b);
        return prod_t'(a) * prod_t'(b);
    endfunction

    function automatic dot_t mul_dp(diff_t a, prod_t b);
        return dot_t'(a) * dot_t'(b);
    endfunction

    function automatic dot_t mul_cp(coord_t a, prod_t b);
        return dot_t'(a) * dot_t'(b);
    endfunction

endpackage

>>> hdl/ray_triangle_intersect_core.sv
// Top level of the ray/triangle intersection core (Moller-Trumbore, back-face culled).
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------
//  in      | input     | in_valid / in_stall        | in_data  (tri_in_t)
//  out     | output    | out_valid / out_stall      | out_data (res_out_t)
//  cfg     | input     | cfg_we, no back-pressure   | cfg_index, cfg_data
//
//  One triangle per cycle sustained while the output takes items; out_valid comes from
//  the output register that follows the five stage regs.
//  Clock period is set by the deepest stage, the dot products: 12 multiplies + 3-input adds.
//  rst_n clears all valid bits and loads the ray registers with their defaults.
//  in_stall comes straight from the skid register: once the output stalls and one
//  more item lands, the whole pipeline freezes until the skid drains.
module ray_triangle_intersect_core #(
    parameter int FRACTION_BITS = rti_pkg::FRACTION_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  rti_pkg::tri_in_t                 in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output rti_pkg::res_out_t                out_data,
    input  logic                             cfg_we,
    input  logic [rti_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rti_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import rti_pkg::*;

    ray_cfg_t cfg_reg;

    logic     adv;        // global pipeline enable
    logic     buf_full;
    logic     geom_valid;
    geom_t    geom;
    logic     dots_valid;
    dots_t    dots;
    logic     res_valid;
    res_out_t res;

    // Ray registers, read live by stages 1-4. The user must write them only while idle;
    // the block does not enforce it. Direction z defaults to 1.0 in the configured format.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x        <= '0;
            cfg_reg.origin_y        <= '0;
            cfg_reg.origin_z        <= '0;
            cfg_reg.dir_x           <= '0;
            cfg_reg.dir_y           <= '0;
            cfg_reg.dir_z           <= coord_t'(1 << FRACTION_BITS);
            cfg_reg.ray_length      <= '1;
            cfg_reg.min_determinant <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ORIGIN_X: cfg_reg.origin_x        <= cfg_data[COORD_W-1:0];
                REG_ORIGIN_Y: cfg_reg.origin_y        <= cfg_data[COORD_W-1:0];
                REG_ORIGIN_Z: cfg_reg.origin_z        <= cfg_data[COORD_W-1:0];
                REG_DIR_X:    cfg_reg.dir_x           <= cfg_data[COORD_W-1:0];
                REG_DIR_Y:    cfg_reg.dir_y           <= cfg_data[COORD_W-1:0];
                REG_DIR_Z:    cfg_reg.dir_z           <= cfg_data[COORD_W-1:0];
                REG_RAY_LEN:  cfg_reg.ray_length      <= cfg_data[COORD_W-1:0];
                REG_MIN_DET:  cfg_reg.min_determinant <= cfg_data[DET_THR_W-1:0];
                default:      ;
            endcase
        end
    end

    // All pipeline stages move together unless the output skid is occupied.
    assign adv      = !buf_full;
    assign in_stall = buf_full;

    // Stages 1-2: differences, then p = dir x e2 and q = s x e1
    rti_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (in_valid),
        .in_data    (in_data),
        .cfg        (cfg_reg),
        .geom_valid (geom_valid),
        .geom       (geom)
    );

    // Stage 3: det, u, v, t numerators
    rti_dot u_dot (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .geom_valid (geom_valid),
        .geom       (geom),
        .cfg        (cfg_reg),
        .dots_valid (dots_valid),
        .dots       (dots)
    );

    // Stages 4-5: compares without division, then outcome priority
    rti_decide #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_decide (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .dots_valid (dots_valid),
        .dots       (dots),
        .cfg        (cfg_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Output register plus skid; pushes only while the pipeline advances
    rti_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid && adv),
        .push_data (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .full      (buf_full)
    );

endmodule

>>> hdl/rti_front.sv
// Front stages: edge/offset differences, then the p and q cross products.
module rti_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  rti_pkg::tri_in_t  in_data,
    input  rti_pkg::ray_cfg_t cfg,
    output logic              geom_valid,
    output rti_pkg::geom_t    geom
);
    import rti_pkg::*;

    // stage 1
    logic             v1_reg;
    logic [TAG_W-1:0] tag1_reg, tag1_next;
    diff_t [2:0]      e1_reg, e1_next;
    diff_t [2:0]      e2_reg, e2_next;
    diff_t [2:0]      s_reg, s_next;

    // stage 2
    logic  v2_reg;
    geom_t geom_reg, geom_next;

    always_comb
    begin
        tag1_next     = in_data.tri_tag;
        e1_next[AX_X] = sub_cc(in_data.vertex_b_x, in_data.vertex_a_x);
        e1_next[AX_Y] = sub_cc(in_data.vertex_b_y, in_data.vertex_a_y);
        e1_next[AX_Z] = sub_cc(in_data.vertex_b_z, in_data.vertex_a_z);
        e2_next[AX_X] = sub_cc(in_data.vertex_c_x, in_data.vertex_a_x);
        e2_next[AX_Y] = sub_cc(in_data.vertex_c_y, in_data.vertex_a_y);
        e2_next[AX_Z] = sub_cc(in_data.vertex_c_z, in_data.vertex_a_z);
        s_next[AX_X]  = sub_cc(cfg.origin_x, in_data.vertex_a_x);
        s_next[AX_Y]  = sub_cc(cfg.origin_y, in_data.vertex_a_y);
        s_next[AX_Z]  = sub_cc(cfg.origin_z, in_data.vertex_a_z);
    end

    always_comb
    begin
        geom_next.tag = tag1_reg;
        geom_next.e1  = e1_reg;
        geom_next.e2  = e2_reg;
        geom_next.s   = s_reg;
        // p = dir x e2
        geom_next.p[AX_X] = mul_cd(cfg.dir_y, e2_reg[AX_Z]) - mul_cd(cfg.dir_z, e2_reg[AX_Y]);
        geom_next.p[AX_Y] = mul_cd(cfg.dir_z, e2_reg[AX_X]) - mul_cd(cfg.dir_x, e2_reg[AX_Z]);
        geom_next.p[AX_Z] = mul_cd(cfg.dir_x, e2_reg[AX_Y]) - mul_cd(cfg.dir_y, e2_reg[AX_X]);
        // q = s x e1
        geom_next.q[AX_X] = mul_dd(s_reg[AX_Y], e1_reg[AX_Z]) - mul_dd(s_reg[AX_Z], e1_reg[AX_Y]);
        geom_next.q[AX_Y] = mul_dd(s_reg[AX_Z], e1_reg[AX_X]) - mul_dd(s_reg[AX_X], e1_reg[AX_Z]);
        geom_next.q[AX_Z] = mul_dd(s_reg[AX_X], e1_reg[AX_Y]) - mul_dd(s_reg[AX_Y], e1_reg[AX_X]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tag1_reg <= tag1_next;
            e1_reg   <= e1_next;
            e2_reg   <= e2_next;
            s_reg    <= s_next;
            geom_reg <= geom_next;
        end
    end

    assign geom_valid = v2_reg;
    assign geom       = geom_reg;

endmodule

>>> hdl/rti_dot.sv
// Dot product stage: determinant and the u, v, t numerators.
module rti_dot (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              geom_valid,
    input  rti_pkg::geom_t    geom,
    input  rti_pkg::ray_cfg_t cfg,
    output logic              dots_valid,
    output rti_pkg::dots_t    dots
);
    import rti_pkg::*;

    logic  v3_reg;
    dots_t dots_reg, dots_next;

    always_comb
    begin
        dots_next.tag = geom.tag;
        dots_next.det = mul_dp(geom.e1[AX_X], geom.p[AX_X])
                      + mul_dp(geom.e1[AX_Y], geom.p[AX_Y])
                      + mul_dp(geom.e1[AX_Z], geom.p[AX_Z]);
        dots_next.un  = mul_dp(geom.s[AX_X], geom.p[AX_X])
                      + mul_dp(geom.s[AX_Y], geom.p[AX_Y])
                      + mul_dp(geom.s[AX_Z], geom.p[AX_Z]);
        dots_next.vn  = mul_cp(cfg.dir_x, geom.q[AX_X])
                      + mul_cp(cfg.dir_y, geom.q[AX_Y])
                      + mul_cp(cfg.dir_z, geom.q[AX_Z]);
        dots_next.tn  = mul_dp(geom.e2[AX_X], geom.q[AX_X])
                      + mul_dp(geom.e2[AX_Y], geom.q[AX_Y])
                      + mul_dp(geom.e2[AX_Z], geom.q[AX_Z]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (adv)
            v3_reg <= geom_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            dots_reg <= dots_next;
    end

    assign dots_valid = v3_reg;
    assign dots       = dots_reg;

endmodule

>>> hdl/rti_decide.sv
// Range tests against the determinant and outcome priority.
module rti_decide #(
    parameter int FRACTION_BITS = rti_pkg::FRACTION_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              dots_valid,
    input  rti_pkg::dots_t    dots,
    input  rti_pkg::ray_cfg_t cfg,
    output logic              res_valid,
    output rti_pkg::res_out_t res
);
    import rti_pkg::*;

    // holds det * length and t_num << F exactly
    localparam int CMP_W = 4 * COORD_W + FRACTION_BITS + 9;
    typedef logic signed [CMP_W-1:0] cmp_t;
    typedef logic signed [DOT_W:0]   sum_t;

    // stage 4
    logic             v4_reg;
    logic [TAG_W-1:0] tag4_reg;
    logic             det_ok_reg, det_ok_next;
    logic             u_bad_reg, u_bad_next;
    logic             v_bad_reg, v_bad_next;
    logic             t_neg_reg, t_neg_next;
    cmp_t             tn_sh_reg, tn_sh_next;
    cmp_t             det_len_reg, det_len_next;
    sum_t             uv_sum;

    // stage 5
    logic     v5_reg;
    res_out_t res_reg, res_next;
    logic     t_bad;

    always_comb
    begin
        det_ok_next  = cmp_t'({1'b0, cfg.min_determinant}) < cmp_t'(dots.det);
        u_bad_next   = dots.un[DOT_W-1] || (dots.un > dots.det);
        uv_sum       = sum_t'(dots.un) + sum_t'(dots.vn);
        v_bad_next   = dots.vn[DOT_W-1] || (uv_sum > sum_t'(dots.det));
        t_neg_next   = dots.tn[DOT_W-1];
        tn_sh_next   = cmp_t'(dots.tn) <<< FRACTION_BITS;
        det_len_next = cmp_t'(dots.det) * cmp_t'({1'b0, cfg.ray_length});
    end

    always_comb
    begin
        t_bad               = t_neg_reg || (tn_sh_reg > det_len_reg);
        res_next.result_tag = tag4_reg;
        if (!det_ok_reg)
            res_next.outcome = OUTC_DET;
        else if (u_bad_reg)
            res_next.outcome = OUTC_U_OUT;
        else if (v_bad_reg)
            res_next.outcome = OUTC_V_OUT;
        else if (t_bad)
            res_next.outcome = OUTC_T_OUT;
        else
            res_next.outcome = OUTC_HIT;
        res_next.hit = (res_next.outcome == OUTC_HIT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v4_reg <= dots_valid;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tag4_reg    <= dots.tag;
            det_ok_reg  <= det_ok_next;
            u_bad_reg   <= u_bad_next;
            v_bad_reg   <= v_bad_next;
            t_neg_reg   <= t_neg_next;
            tn_sh_reg   <= tn_sh_next;
            det_len_reg <= det_len_next;
            res_reg     <= res_next;
        end
    end

    assign res_valid = v5_reg;
    assign res       = res_reg;

    a_hit_matches_code: assert property (@(posedge clk) disable iff (!rst_n)
        v5_reg |-> (res_reg.hit == (res_reg.outcome == OUTC_HIT)))
        else $error("hit flag disagrees with outcome");

    a_frozen_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v5_reg && !adv) |=> (v5_reg && $stable(res_reg)))
        else $error("last stage changed while frozen");

endmodule

>>> hdl/rti_obuf.sv
// Output register with one skid entry; full skid freezes the pipeline.
module rti_obuf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rti_pkg::res_out_t push_data,
    input  logic              out_stall,
    output logic              out_valid,
    output rti_pkg::res_out_t out_data,
    output logic              full
);
    import rti_pkg::*;

    logic     out_valid_reg, out_valid_next;
    logic     skid_valid_reg, skid_valid_next;
    res_out_t out_data_reg, out_data_next;
    res_out_t skid_data_reg, skid_data_next;
    logic     take;

    always_comb
    begin
        take            = out_valid_reg && !out_stall;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || take)
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign full      = skid_valid_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds an item while output is empty");

    a_skid_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_stall) |=> (skid_valid_reg && $stable(skid_data_reg)))
        else $error("skid item lost under stall");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !push)
        else $error("item pushed into full buffer");

endmodule
